/* hdl/hbc_pkg.sv */
`timescale 1ns / 1ps

package hbc_pkg;

	// bridge count is fixed by the per-bridge output fields
	localparam int BRIDGES = 2;
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_FULL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_HOLDOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 2'd2;

	// configuration reset values
	localparam logic [15:0] PWM_FULL_SCALE_RST = 16'd1000;
	localparam logic [15:0] FAULT_HOLDOFF_RST = 16'd100;
	localparam logic [BRIDGES-1:0] INVERT_MASK_RST = '0;

	// power saturation and duty rounding
	localparam int MAG_W = 10;
	localparam logic [MAG_W-1:0] POWER_LIMIT = 10'd1000;
	localparam logic signed [15:0] POWER_MAX = 16'sd1000;
	localparam logic signed [15:0] POWER_MIN = -16'sd1000;
	localparam int SUM_W = 26;
	localparam logic [SUM_W-1:0] ROUND_HALF = 26'd500;

	// divide by 1000: drop three bits, then multiply by ceil(2^30 / 125)
	localparam int DIV_PRE_SHIFT = 3;
	localparam int DIV_N_W = SUM_W - DIV_PRE_SHIFT;
	localparam int RECIP_W = 24;
	localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;
	localparam int RECIP_SHIFT = 30;
	localparam int PROD_W = DIV_N_W + RECIP_W;

	typedef enum logic [2:0] {
		OP_TICK         = 3'd0,
		OP_ENABLE       = 3'd1,
		OP_DISABLE      = 3'd2,
		OP_SET_POWER    = 3'd3,
		OP_STOP         = 3'd4,
		OP_STOP_ALL     = 3'd5,
		OP_CLEAR_FAULTS = 3'd6
	} op_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic               bridge;
		logic               all_bridges;
		logic signed [15:0] power_permille;
		logic               fault_pin_low;
		logic               otw_pin_low;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic [15:0]        fwd_duty_a;
		logic [15:0]        rev_duty_a;
		logic [15:0]        fwd_duty_b;
		logic [15:0]        rev_duty_b;
		logic [BRIDGES-1:0] reset_level_mask;
		logic [BRIDGES-1:0] reset_pulse_mask;
		logic               fault_active;
		logic               overtemp_warning;
		logic [15:0]        holdoff_left;
	} out_item_t;

	// classified command fields carried through the front pipeline
	typedef struct packed {
		logic [2:0] operation;
		logic       bridge;
		logic       all_bridges;
		logic       req_zero;
		logic       neg;
		logic       fault;
		logic       otw;
	} cmd_ctl_t;

	// queue entry handed from front to back
	typedef struct packed {
		cmd_ctl_t    ctl;
		logic [15:0] duty;
	} cmd_t;

endpackage

/* hdl/hbc_front.sv */
`timescale 1ns / 1ps

module hbc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  hbc_pkg::in_item_t   in_data,
	input  logic [15:0]         pwm_full_scale,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output hbc_pkg::cmd_t       cmd_data
);

	logic                          v_s1, v_s2, v_s3;
	logic                          rdy_s1, rdy_s2, rdy_s3;
	hbc_pkg::cmd_ctl_t             ctl_in, ctl_s1, ctl_s2, ctl_s3;
	logic [hbc_pkg::MAG_W-1:0]     mag_in, mag_s1;
	logic signed [15:0]            abs_in;
	logic [hbc_pkg::SUM_W-1:0]     sum_s2;
	logic [hbc_pkg::PROD_W-1:0]    prod_s3;
	logic [hbc_pkg::PROD_W-1:0]    quot;
	logic [15:0]                   duty;

	// stage handshake, each stage loads when empty or draining
	assign rdy_s3 = !v_s3 || cmd_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// classify and saturate the request
	always_comb begin
		abs_in = in_data.power_permille[15] ? -in_data.power_permille : in_data.power_permille;
		if (in_data.power_permille > hbc_pkg::POWER_MAX ||
				in_data.power_permille < hbc_pkg::POWER_MIN) begin
			mag_in = hbc_pkg::POWER_LIMIT;
		end else begin
			mag_in = abs_in[hbc_pkg::MAG_W-1:0];
		end
		ctl_in.operation = in_data.operation;
		ctl_in.bridge = in_data.bridge;
		ctl_in.all_bridges = in_data.all_bridges;
		ctl_in.req_zero = (in_data.power_permille == 16'sd0);
		ctl_in.neg = in_data.power_permille[15];
		ctl_in.fault = in_data.fault_pin_low;
		ctl_in.otw = in_data.otw_pin_low;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// payload: scale by full scale, add rounding, then reciprocal multiply
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ctl_s1 <= ctl_in;
			mag_s1 <= mag_in;
		end
		if (rdy_s2 && v_s1) begin
			ctl_s2 <= ctl_s1;
			sum_s2 <= hbc_pkg::SUM_W'(mag_s1) * hbc_pkg::SUM_W'(pwm_full_scale)
				+ hbc_pkg::ROUND_HALF;
		end
		if (rdy_s3 && v_s2) begin
			ctl_s3 <= ctl_s2;
			prod_s3 <= sum_s2[hbc_pkg::SUM_W-1:hbc_pkg::DIV_PRE_SHIFT] * hbc_pkg::RECIP_125;
		end
	end

	// quotient, with a floor of one for nonzero power
	always_comb begin
		quot = prod_s3 >> hbc_pkg::RECIP_SHIFT;
		duty = quot[15:0];
		if (ctl_s3.req_zero) begin
			duty = 16'd0;
		end else if (duty == 16'd0) begin
			duty = 16'd1;
		end
	end

	assign cmd_valid = v_s3;
	assign cmd_data.ctl = ctl_s3;
	assign cmd_data.duty = duty;

endmodule

/* hdl/hbc_queue.sv */
`timescale 1ns / 1ps

module hbc_queue #(
	parameter int DEPTH = hbc_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  hbc_pkg::cmd_t  push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output hbc_pkg::cmd_t  pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	hbc_pkg::cmd_t    mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/hbc_back.sv */
`timescale 1ns / 1ps

module hbc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  hbc_pkg::cmd_t               cmd_data,
	input  logic [15:0]                 fault_holdoff_ticks,
	input  logic [hbc_pkg::BRIDGES-1:0] invert_mask,
	output logic                        out_valid,
	input  logic                        out_stall,
	output hbc_pkg::out_item_t          out_data
);

	localparam int NB = hbc_pkg::BRIDGES;

	logic [NB-1:0]      en_q, nz_q, neg_q;
	logic [15:0]        duty_q [NB];
	logic               fault_q;
	logic [15:0]        holdoff_q;
	logic               out_valid_q;
	hbc_pkg::out_item_t out_q;

	logic [NB-1:0]      en_d, nz_d, neg_d;
	logic [15:0]        duty_d [NB];
	logic [15:0]        hc_d;
	logic [15:0]        remaining;
	logic               acc;
	logic [NB-1:0]      pulse;
	logic [15:0]        fwd [NB];
	logic [15:0]        rev [NB];
	logic               take;
	hbc_pkg::cmd_ctl_t  c;
	hbc_pkg::out_item_t out_d;

	assign c = cmd_data.ctl;
	assign take = cmd_valid && (!out_valid_q || !out_stall);
	assign cmd_ready = !out_valid_q || !out_stall;

	// holdoff counter: tick first, then pin sampling
	always_comb begin
		hc_d = holdoff_q;
		if (hbc_pkg::op_t'(c.operation) == hbc_pkg::OP_TICK && holdoff_q != 16'd0) begin
			hc_d = holdoff_q - 16'd1;
		end
		if (c.fault && !fault_q) begin
			hc_d = fault_holdoff_ticks;
		end
		if (!c.fault) begin
			hc_d = 16'd0;
		end
		remaining = hc_d;
	end

	// command execution
	always_comb begin
		en_d = en_q;
		nz_d = nz_q;
		neg_d = neg_q;
		duty_d = duty_q;
		acc = 1'b0;
		pulse = '0;
		case (hbc_pkg::op_t'(c.operation))
			hbc_pkg::OP_TICK: begin
				acc = 1'b1;
			end
			hbc_pkg::OP_ENABLE: begin
				if (remaining == 16'd0) begin
					en_d[c.bridge] = 1'b1;
					pulse = NB'(1) << c.bridge;
					acc = 1'b1;
				end
			end
			hbc_pkg::OP_DISABLE: begin
				en_d[c.bridge] = 1'b0;
				nz_d[c.bridge] = 1'b0;
				duty_d[c.bridge] = 16'd0;
				acc = 1'b1;
			end
			hbc_pkg::OP_SET_POWER: begin
				if (en_q[c.bridge] || c.req_zero) begin
					nz_d[c.bridge] = !c.req_zero;
					neg_d[c.bridge] = c.neg;
					duty_d[c.bridge] = cmd_data.duty;
					acc = 1'b1;
				end
			end
			hbc_pkg::OP_STOP: begin
				nz_d[c.bridge] = 1'b0;
				duty_d[c.bridge] = 16'd0;
				acc = 1'b1;
			end
			hbc_pkg::OP_STOP_ALL: begin
				nz_d = '0;
				for (int i = 0; i < NB; i++) begin
					duty_d[i] = 16'd0;
				end
				acc = 1'b1;
			end
			hbc_pkg::OP_CLEAR_FAULTS: begin
				if (remaining == 16'd0) begin
					pulse = c.all_bridges ? {NB{1'b1}} : (NB'(1) << c.bridge);
					acc = 1'b1;
				end
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	// pwm pin selection per bridge
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			fwd[i] = 16'd0;
			rev[i] = 16'd0;
			if (en_d[i] && nz_d[i]) begin
				if (neg_d[i] ^ invert_mask[i]) begin
					rev[i] = duty_d[i];
				end else begin
					fwd[i] = duty_d[i];
				end
			end
		end
	end

	// result beat
	always_comb begin
		out_d.accepted = acc;
		out_d.fwd_duty_a = fwd[0];
		out_d.rev_duty_a = rev[0];
		out_d.fwd_duty_b = fwd[1];
		out_d.rev_duty_b = rev[1];
		out_d.reset_level_mask = en_d;
		out_d.reset_pulse_mask = pulse;
		out_d.fault_active = c.fault;
		out_d.overtemp_warning = c.otw;
		out_d.holdoff_left = remaining;
	end

	// bridge and fault state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			nz_q <= '0;
			neg_q <= '0;
			for (int i = 0; i < NB; i++) begin
				duty_q[i] <= 16'd0;
			end
			fault_q <= 1'b0;
			holdoff_q <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				en_q <= en_d;
				nz_q <= nz_d;
				neg_q <= neg_d;
				duty_q <= duty_d;
				fault_q <= c.fault;
				holdoff_q <= hc_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

/* hdl/dual_hbridge_command_controller_top.sv */
`timescale 1ns / 1ps
// path: a command beat passes the front stages, the queue and the back-end output register before its result beat
// throughput: one command per cycle while out_stall is low, bounded by the registered state update in the back end
// the duty pipeline (saturate, scale, reciprocal divide) is 3 stages ahead of a 4-entry queue
// reset: bridges disabled, power and duty zero, no fault latched, holdoff count zero,
// registers at full scale 1000, holdoff 100 ticks, no inversion; no clearing pass

module dual_hbridge_command_controller_top #(
	parameter int QUEUE_DEPTH = hbc_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  hbc_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output hbc_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	logic [15:0]                 pwm_full_scale_q;
	logic [15:0]                 fault_holdoff_q;
	logic [hbc_pkg::BRIDGES-1:0] invert_mask_q;

	logic          f_valid, f_ready;
	hbc_pkg::cmd_t f_data;
	logic          b_valid, b_ready;
	hbc_pkg::cmd_t b_data;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_full_scale_q <= hbc_pkg::PWM_FULL_SCALE_RST;
			fault_holdoff_q <= hbc_pkg::FAULT_HOLDOFF_RST;
			invert_mask_q <= hbc_pkg::INVERT_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hbc_pkg::CFG_PWM_FULL_SCALE: pwm_full_scale_q <= cfg_data;
				hbc_pkg::CFG_FAULT_HOLDOFF:  fault_holdoff_q <= cfg_data;
				hbc_pkg::CFG_INVERT_MASK:    invert_mask_q <= cfg_data[hbc_pkg::BRIDGES-1:0];
				default: begin
				end
			endcase
		end
	end

	hbc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.pwm_full_scale (pwm_full_scale_q),
		.cmd_valid      (f_valid),
		.cmd_ready      (f_ready),
		.cmd_data       (f_data)
	);

	hbc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	hbc_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd_valid           (b_valid),
		.cmd_ready           (b_ready),
		.cmd_data            (b_data),
		.fault_holdoff_ticks (fault_holdoff_q),
		.invert_mask         (invert_mask_q),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.out_data            (out_data)
	);

endmodule

/* test/dual_hbridge_command_controller_top_tb.sv */
`timescale 1ns / 1ps

module dual_hbridge_command_controller_top_tb;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int POWER_CAP = 1000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD = 80;
	localparam int QUIET_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	hbc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	hbc_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	dual_hbridge_command_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// register copies for the bridge predictor
	logic [15:0] full_scale_cfg = 16'd1000;
	logic [15:0] holdoff_cfg = 16'd100;
	logic [hbc_pkg::BRIDGES-1:0] invert_cfg = '0;

	// bridge and fault state for the predictor
	logic [hbc_pkg::BRIDGES-1:0] drv_enabled = '0;
	int drv_power [hbc_pkg::BRIDGES] = '{0, 0};
	logic [15:0] drv_duty [hbc_pkg::BRIDGES] = '{16'd0, 16'd0};
	logic fault_seen = 1'b0;
	logic [15:0] holdoff_cnt = '0;

	hbc_pkg::in_item_t cmd_pending_q [$];
	hbc_pkg::out_item_t bridge_expect_q [$];
	hbc_pkg::out_item_t want_beat;
	int items_total = 0;
	int results_done = 0;
	int mismatch_count = 0;
	logic in_beat_taken = 1'b0;

	// idling knobs, set per phase
	int send_gap_max = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int stall_run = 0;
	int burst_left = 1;
	int gap_left = 0;
	int quiet_cycles = 0;
	logic fault_level = 1'b0;

	// next bridge outputs for one command, updating predictor state
	function automatic hbc_pkg::out_item_t predict_bridge_outputs(input hbc_pkg::in_item_t cmd);
		hbc_pkg::out_item_t res;
		int b;
		int req;
		int applied;
		int unsigned mag;
		int unsigned scaled;
		logic [15:0] duty;
		logic [15:0] remaining;
		logic [hbc_pkg::BRIDGES-1:0] pulse;
		logic ok;
		logic [15:0] fwd [hbc_pkg::BRIDGES];
		logic [15:0] rev [hbc_pkg::BRIDGES];
		b = int'(cmd.bridge);
		req = int'($signed(cmd.power_permille));
		ok = 1'b0;
		pulse = '0;

		// tick countdown, then fault pin sampling
		if (cmd.operation == hbc_pkg::OP_TICK && holdoff_cnt != 0)
			holdoff_cnt = holdoff_cnt - 16'd1;
		if (cmd.fault_pin_low && !fault_seen)
			holdoff_cnt = holdoff_cfg;
		if (!cmd.fault_pin_low)
			holdoff_cnt = '0;
		fault_seen = cmd.fault_pin_low;
		remaining = fault_seen ? holdoff_cnt : 16'd0;

		case (cmd.operation)
			hbc_pkg::OP_TICK: ok = 1'b1;
			hbc_pkg::OP_ENABLE: begin
				if (remaining == 0) begin
					drv_enabled[b] = 1'b1;
					pulse[b] = 1'b1;
					ok = 1'b1;
				end
			end
			hbc_pkg::OP_DISABLE: begin
				drv_enabled[b] = 1'b0;
				drv_power[b] = 0;
				drv_duty[b] = '0;
				ok = 1'b1;
			end
			hbc_pkg::OP_SET_POWER: begin
				if (drv_enabled[b] || req == 0) begin
					if (req > POWER_CAP)
						req = POWER_CAP;
					else if (req < -POWER_CAP)
						req = -POWER_CAP;
					mag = (req < 0) ? -req : req;
					duty = '0;
					if (mag > 0) begin
						scaled = (mag * full_scale_cfg + 500) / 1000;
						duty = scaled[15:0];
						if (duty == 0)
							duty = 16'd1;
					end
					drv_power[b] = req;
					drv_duty[b] = duty;
					ok = 1'b1;
				end
			end
			hbc_pkg::OP_STOP: begin
				drv_power[b] = 0;
				drv_duty[b] = '0;
				ok = 1'b1;
			end
			hbc_pkg::OP_STOP_ALL: begin
				for (int i = 0; i < hbc_pkg::BRIDGES; i++) begin
					drv_power[i] = 0;
					drv_duty[i] = '0;
				end
				ok = 1'b1;
			end
			hbc_pkg::OP_CLEAR_FAULTS: begin
				if (remaining == 0) begin
					pulse = cmd.all_bridges ? '1 : '0;
					pulse[b] = 1'b1;
					ok = 1'b1;
				end
			end
			default: ok = 1'b0;
		endcase

		// pick the driven pin per bridge
		for (int i = 0; i < hbc_pkg::BRIDGES; i++) begin
			applied = invert_cfg[i] ? -drv_power[i] : drv_power[i];
			fwd[i] = '0;
			rev[i] = '0;
			if (drv_enabled[i] && applied > 0)
				fwd[i] = drv_duty[i];
			else if (drv_enabled[i] && applied < 0)
				rev[i] = drv_duty[i];
		end

		res.accepted = ok;
		res.fwd_duty_a = fwd[0];
		res.rev_duty_a = rev[0];
		res.fwd_duty_b = fwd[1];
		res.rev_duty_b = rev[1];
		res.reset_level_mask = drv_enabled;
		res.reset_pulse_mask = pulse;
		res.fault_active = fault_seen;
		res.overtemp_warning = cmd.otw_pin_low;
		res.holdoff_left = remaining;
		return res;
	endfunction

	function automatic hbc_pkg::in_item_t make_cmd(input logic [2:0] op, input logic bridge,
			input logic all_bridges, input logic signed [15:0] power,
			input logic fault, input logic otw);
		hbc_pkg::in_item_t c;
		c.operation = op;
		c.bridge = bridge;
		c.all_bridges = all_bridges;
		c.power_permille = power;
		c.fault_pin_low = fault;
		c.otw_pin_low = otw;
		return c;
	endfunction

	// random command, mostly meaningful ops with a slowly changing fault pin
	function automatic hbc_pkg::in_item_t random_cmd();
		hbc_pkg::in_item_t c;
		int w;
		logic signed [15:0] p;
		w = int'($urandom_range(0, 99));
		if (w < 22)
			c.operation = hbc_pkg::OP_TICK;
		else if (w < 38)
			c.operation = hbc_pkg::OP_ENABLE;
		else if (w < 46)
			c.operation = hbc_pkg::OP_DISABLE;
		else if (w < 72)
			c.operation = hbc_pkg::OP_SET_POWER;
		else if (w < 80)
			c.operation = hbc_pkg::OP_STOP;
		else if (w < 85)
			c.operation = hbc_pkg::OP_STOP_ALL;
		else if (w < 95)
			c.operation = hbc_pkg::OP_CLEAR_FAULTS;
		else
			c.operation = OP_UNUSED;
		case ($urandom_range(0, 5))
			0: p = 16'($urandom_range(0, 65535));
			1: p = 16'($signed($urandom_range(0, 2000)) - 1000);
			2: p = $urandom_range(0, 1) ? 16'sd1000 : -16'sd1001;
			3: p = 16'($signed($urandom_range(0, 10)) - 5);
			4: p = '0;
			default: begin
				p = 16'($urandom_range(1001, 32767));
				if ($urandom_range(0, 1))
					p = -p;
			end
		endcase
		c.power_permille = p;
		c.bridge = 1'($urandom_range(0, 1));
		c.all_bridges = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 15) == 0)
			fault_level = ~fault_level;
		c.fault_pin_low = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : fault_level;
		c.otw_pin_low = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic queue_cmd(input hbc_pkg::in_item_t c);
		cmd_pending_q.push_back(c);
		items_total++;
	endtask

	task automatic queue_random(input int n);
		repeat (n) queue_cmd(random_cmd());
	endtask

	// wait for every result, then let the pipeline settle
	task automatic wait_drained();
		while (results_done != items_total) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [hbc_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hbc_pkg::CFG_PWM_FULL_SCALE: full_scale_cfg = value;
			hbc_pkg::CFG_FAULT_HOLDOFF: holdoff_cfg = value;
			hbc_pkg::CFG_INVERT_MASK: invert_cfg = value[hbc_pkg::BRIDGES-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_registers(input logic [15:0] scale, input logic [15:0] holdoff,
			input logic [hbc_pkg::BRIDGES-1:0] invert);
		write_register(hbc_pkg::CFG_PWM_FULL_SCALE, scale);
		write_register(hbc_pkg::CFG_FAULT_HOLDOFF, holdoff);
		write_register(hbc_pkg::CFG_INVERT_MASK, 16'(invert));
	endtask

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			$display("mismatch on %s: got %0d, expected %0d", what, got, want);
			mismatch_count++;
		end
	endtask

	task automatic check_result(input hbc_pkg::out_item_t got, input hbc_pkg::out_item_t want);
		flag_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
		flag_mismatch("fwd_duty_a", 32'(got.fwd_duty_a), 32'(want.fwd_duty_a));
		flag_mismatch("rev_duty_a", 32'(got.rev_duty_a), 32'(want.rev_duty_a));
		flag_mismatch("fwd_duty_b", 32'(got.fwd_duty_b), 32'(want.fwd_duty_b));
		flag_mismatch("rev_duty_b", 32'(got.rev_duty_b), 32'(want.rev_duty_b));
		flag_mismatch("reset_level_mask", 32'(got.reset_level_mask),
			32'(want.reset_level_mask));
		flag_mismatch("reset_pulse_mask", 32'(got.reset_pulse_mask),
			32'(want.reset_pulse_mask));
		flag_mismatch("fault_active", 32'(got.fault_active), 32'(want.fault_active));
		flag_mismatch("overtemp_warning", 32'(got.overtemp_warning),
			32'(want.overtemp_warning));
		flag_mismatch("holdoff_left", 32'(got.holdoff_left), 32'(want.holdoff_left));
	endtask

	// command driver: bursts with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_beat_taken) begin
			// stalled beat keeps its payload
		end else if (gap_left != 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (cmd_pending_q.size() != 0) begin
			in_data <= cmd_pending_q.pop_front();
			in_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= int'($urandom_range(1, 16));
				gap_left <= int'($urandom_range(0, send_gap_max));
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result receiver: long hold on request, otherwise random stall runs
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
			stall_run <= int'($urandom_range(0, 4));
		end
	end

	// monitor: predict on each command beat, check each result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				bridge_expect_q.push_back(predict_bridge_outputs(in_data));
			if (out_valid && !out_stall) begin
				if (bridge_expect_q.size() == 0) begin
					flag_mismatch("unexpected result beat", 1, 0);
				end else begin
					want_beat = bridge_expect_q.pop_front();
					check_result(out_data, want_beat);
					results_done++;
				end
			end
		end
		in_beat_taken = arst_n && in_valid && !in_stall;
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[dual_hbridge_command_controller_top] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// reset registers: directed commands then random
		send_gap_max = 3;
		stall_pct = 30;
		queue_cmd(make_cmd(hbc_pkg::OP_TICK, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b0, 1'b0, 16'sd500, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b1, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_ENABLE, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_ENABLE, 1'b1, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b0, 1'b0, 16'sh7fff, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b1, 1'b1, 16'sh8000, 1'b0, 1'b1));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b0, 1'b0, 16'sd1, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b1, 1'b0, -16'sd1, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_STOP, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_STOP_ALL, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b0, 1'b0, -16'sd700, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_DISABLE, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(OP_UNUSED, 1'b1, 1'b1, 16'shffff, 1'b0, 1'b1));
		// fault edge blocks enable and clear until the pin drops
		queue_cmd(make_cmd(hbc_pkg::OP_TICK, 1'b0, 1'b0, 16'sd0, 1'b1, 1'b1));
		queue_cmd(make_cmd(hbc_pkg::OP_ENABLE, 1'b0, 1'b0, 16'sd0, 1'b1, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_CLEAR_FAULTS, 1'b0, 1'b1, 16'sd0, 1'b1, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_TICK, 1'b0, 1'b0, 16'sd0, 1'b1, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_CLEAR_FAULTS, 1'b1, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_CLEAR_FAULTS, 1'b0, 1'b1, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b1, 1'b1, 16'sd1000, 1'b0, 1'b0));
		queue_random(80);
		wait_drained();

		// largest scale, no holdoff, both bridges inverted, no idling
		send_gap_max = 0;
		stall_pct = 0;
		set_registers(16'hffff, 16'd0, 2'b11);
		queue_random(100);
		wait_drained();

		// smallest scale gives the minimum duty, longest holdoff, heavy idling
		send_gap_max = 6;
		stall_pct = 50;
		set_registers(16'd1, 16'hffff, 2'b01);
		queue_cmd(make_cmd(hbc_pkg::OP_ENABLE, 1'b0, 1'b0, 16'sd0, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b0, 1'b0, 16'sd1, 1'b0, 1'b0));
		queue_cmd(make_cmd(hbc_pkg::OP_SET_POWER, 1'b0, 1'b0, -16'sd1000, 1'b0, 1'b0));
		queue_random(100);
		wait_drained();

		// short holdoff, receiver holds off while commands keep coming
		send_gap_max = 0;
		stall_pct = 20;
		set_registers(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 8)), 2'b10);
		hold_requests++;
		queue_random(120);
		wait_drained();

		// random registers
		send_gap_max = 2;
		stall_pct = 15;
		set_registers(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 4)),
			2'($urandom_range(0, 3)));
		queue_random(100);
		wait_drained();

		flag_mismatch("leftover expectations", bridge_expect_q.size(), 0);
		if (mismatch_count == 0)
			$display("[dual_hbridge_command_controller_top] OK");
		else
			$display("[dual_hbridge_command_controller_top] ERROR");
		$finish;
	end

endmodule
